// ----- sv/xbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR binary trie multiset - shared types and constants
// Key and counter widths, request codes, the queue entry and the result record.
// ----------------------------------------------------------------------------
package xbt_pkg;

  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 16;
  localparam int RANK_W     = 16;
  localparam int FUNC_W     = 3;
  localparam int STATUS_W   = 2;

  localparam int NODE_W = KEY_BITS + 1;
  localparam int CMP_W  = (RANK_W > COUNT_BITS) ? RANK_W : COUNT_BITS;

  localparam int S_DATA_W  = KEY_BITS + RANK_W;
  localparam int S_TDATA_W = ((S_DATA_W + 7) / 8) * 8;
  localparam int M_DATA_W  = COUNT_BITS + KEY_BITS + COUNT_BITS;
  localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FUNC_ADD = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_DEL = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_CNT = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FUNC_KTH = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FUNC_XOR = FUNC_W'(4);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_DEL,
    OP_CNT,
    OP_KTH,
    OP_XOR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_BITS-1:0] key;
    logic [RANK_W-1:0]   rank;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    status_t               status;
    logic [COUNT_BITS-1:0] key_count;
    logic [KEY_BITS-1:0]   kth_value;
    logic [COUNT_BITS-1:0] total;
  } res_t;

endpackage

// ----- sv/xbt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR binary trie multiset - front end
// Accepts requests, decodes the function code and queues them for the engine.
// ----------------------------------------------------------------------------
module xbt_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [xbt_pkg::S_TDATA_W-1:0]  s_tdata,   // key, rank
  input  logic [xbt_pkg::FUNC_W-1:0]     s_tuser,   // func
  input  logic                           hold,
  output xbt_pkg::q_head_t               head,
  input  logic                           pop
);
  import xbt_pkg::*;

  localparam int QDEPTH = 2;

  req_t       q [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  req_t       req_in;
  logic       push;

  always_comb begin
    req_in.key  = s_tdata[KEY_BITS-1:0];
    req_in.rank = s_tdata[KEY_BITS +: RANK_W];
    unique case (s_tuser)
      FUNC_ADD: req_in.op = OP_ADD;
      FUNC_DEL: req_in.op = OP_DEL;
      FUNC_CNT: req_in.op = OP_CNT;
      FUNC_KTH: req_in.op = OP_KTH;
      FUNC_XOR: req_in.op = OP_XOR;
      default:  req_in.op = OP_NOP;
    endcase
  end

  assign s_tready   = (cnt != 2'(QDEPTH)) && !hold;
  assign push       = s_tvalid && s_tready;
  assign head.valid = (cnt != 2'd0);
  assign head.req   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- sv/xbt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR binary trie multiset - engine
// Holds the heap-ordered counter memory and the xor mask, walks the tree one
// level a cycle and registers the result.
// ----------------------------------------------------------------------------
module xbt_back (
  input  logic                           clk,
  input  logic                           rst,
  input  xbt_pkg::q_head_t               head,
  output logic                           pop,
  output logic                           clearing,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [xbt_pkg::M_TDATA_W-1:0]  m_tdata,   // key_count, kth_value, total
  output logic [xbt_pkg::STATUS_W-1:0]   m_tuser    // status
);
  import xbt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UP,
    S_CNT,
    S_KTH
  } state_t;

  localparam int NODES = 2 << KEY_BITS;

  logic [COUNT_BITS-1:0] mem [NODES];

  state_t                state;
  logic [NODE_W-1:0]     clr_addr;
  logic [NODE_W-1:0]     node;
  logic                  dir_up;
  logic                  first;
  logic [KEY_BITS-1:0]   mask;
  logic [KEY_BITS-1:0]   msh;
  logic [KEY_BITS-1:0]   val;
  logic [COUNT_BITS-1:0] r;
  logic [COUNT_BITS-1:0] total;
  res_t                  res;

  logic [COUNT_BITS-1:0] rdata;
  logic [NODE_W-1:0]     raddr;
  logic [NODE_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;
  logic                  we;

  logic [KEY_BITS-1:0]   phys;
  logic [NODE_W-1:0]     leaf;
  logic [NODE_W-1:0]     root_child;
  logic                  out_free;
  logic                  take;
  logic                  res_ld;
  logic [COUNT_BITS-1:0] upd;
  logic                  absent;
  logic                  go_left;
  logic [NODE_W-1:0]     chosen;
  logic [NODE_W-1:0]     kth_next;
  logic [COUNT_BITS-1:0] r_next;
  logic [KEY_BITS-1:0]   val_next;
  logic [CMP_W-1:0]      rank_x;
  logic [CMP_W-1:0]      total_x;

  always_comb begin
    phys       = head.req.key ^ mask;
    leaf       = {1'b1, phys};
    root_child = NODE_W'({1'b1, mask[KEY_BITS-1]});
    out_free   = !m_tvalid || m_tready;
    take       = (state == S_IDLE) && head.valid && out_free;
    upd        = dir_up ? rdata + COUNT_BITS'(1) : rdata - COUNT_BITS'(1);
    absent     = first && !dir_up && (rdata == '0);
    go_left    = rdata > r;
    chosen     = go_left ? node : node ^ NODE_W'(1);
    r_next     = go_left ? r : r - rdata;
    val_next   = (val << 1) | KEY_BITS'(!go_left);
    kth_next   = {chosen[NODE_W-2:0], msh[KEY_BITS-1]};
    rank_x     = CMP_W'(head.req.rank);
    total_x    = CMP_W'(total);
  end

  always_comb begin
    unique case (state)
      S_IDLE:  res_ld = take && !((head.req.op == OP_ADD && total != '1) ||
                                  head.req.op == OP_DEL || head.req.op == OP_CNT ||
                                  (head.req.op == OP_KTH && rank_x < total_x));
      S_UP:    res_ld = absent || (node == NODE_W'(1));
      S_CNT:   res_ld = 1'b1;
      S_KTH:   res_ld = node[KEY_BITS];
      default: res_ld = 1'b0;
    endcase
  end

  always_comb begin
    unique case (state)
      S_IDLE:  raddr = (head.req.op == OP_KTH) ? root_child : leaf;
      S_UP:    raddr = node >> 1;
      S_KTH:   raddr = kth_next;
      default: raddr = leaf;
    endcase
    we    = (state == S_CLEAR) || ((state == S_UP) && !absent);
    waddr = (state == S_CLEAR) ? clr_addr : node;
    wdata = (state == S_CLEAR) ? '0 : upd;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign pop      = take;
  assign clearing = (state == S_CLEAR);
  assign m_tdata  = M_TDATA_W'({res.total, res.kth_value, res.key_count});
  assign m_tuser  = res.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      mask     <= '0;
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= res_ld || (m_tvalid && !m_tready);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            unique case (head.req.op)
              OP_ADD: begin
                if (total == '1) begin
                  res <= '{ST_FULL, '0, '0, total};
                end else begin
                  node   <= leaf;
                  dir_up <= 1'b1;
                  first  <= 1'b1;
                  state  <= S_UP;
                end
              end
              OP_DEL: begin
                node   <= leaf;
                dir_up <= 1'b0;
                first  <= 1'b1;
                state  <= S_UP;
              end
              OP_CNT: begin
                state <= S_CNT;
              end
              OP_KTH: begin
                if (rank_x >= total_x) begin
                  res <= '{ST_RANGE, '0, '0, total};
                end else begin
                  node  <= root_child;
                  r     <= COUNT_BITS'(head.req.rank);
                  val   <= '0;
                  msh   <= mask << 1;
                  state <= S_KTH;
                end
              end
              OP_XOR: begin
                mask <= mask ^ head.req.key;
                res  <= '{ST_OK, '0, '0, total};
              end
              default: begin
                res <= '{ST_OK, '0, '0, total};
              end
            endcase
          end
        end
        S_UP: begin
          first <= 1'b0;
          if (absent) begin
            res   <= '{ST_ABSENT, '0, '0, total};
            state <= S_IDLE;
          end else if (node == NODE_W'(1)) begin
            total <= upd;
            res   <= '{ST_OK, '0, '0, upd};
            state <= S_IDLE;
          end else begin
            node <= node >> 1;
          end
        end
        S_CNT: begin
          res   <= '{ST_OK, rdata, '0, total};
          state <= S_IDLE;
        end
        S_KTH: begin
          if (node[KEY_BITS]) begin
            res   <= '{ST_OK, '0, val_next, total};
            state <= S_IDLE;
          end else begin
            node <= kth_next;
            r    <= r_next;
            val  <= val_next;
            msh  <= msh << 1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/xor_binary_trie_multiset.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XOR binary trie multiset - top level
// Multiset of keys kept as a heap of occurrence counters behind a global xor
// mask: add, delete, count, k-th smallest and xor-all requests.
//
//   port group  dir  tdata fields (low first)       tuser
//   s_*         in   key, rank                      func
//   m_*         out  key_count, kth_value, total    status
//
// Add and delete do one counter read-modify-write per tree level in the
// engine, leaf to root; k-th smallest walks one level per cycle from root
// down; count and a delete of an absent key finish after a single counter
// read; xor, refused adds, out-of-range ranks and unused codes finish in
// the idle state. Requests pass through a two-entry request queue.
// After reset the engine zeroes all 2^(KEY_BITS+1) counters, one per cycle
// (2048 counters), with s_tready low. A stalled m_* result holds the engine;
// the queue keeps taking requests until full.
// ----------------------------------------------------------------------------
module xor_binary_trie_multiset (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [xbt_pkg::S_TDATA_W-1:0]  s_tdata,   // key, rank
  input  logic [xbt_pkg::FUNC_W-1:0]     s_tuser,   // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [xbt_pkg::M_TDATA_W-1:0]  m_tdata,   // key_count, kth_value, total
  output logic [xbt_pkg::STATUS_W-1:0]   m_tuser    // status
);
  import xbt_pkg::*;

  q_head_t head;
  logic    pop;
  logic    clearing;

  xbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .hold     (clearing),
    .head     (head),
    .pop      (pop)
  );

  xbt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
